/* hdl/des_pkg.sv */
// ----------------------------------------------------------------------------
// des_pkg
// Shared types and widths for the descending exchange sorter.
// ----------------------------------------------------------------------------
package des_pkg;

   localparam int KEY_W   = 32;
   localparam int TAG_W   = 16;
   localparam int ENTRY_W = KEY_W + TAG_W;

   // one stored pair; key sits in the low bits, as on the stream buses
   typedef struct packed {
      logic [TAG_W-1:0]        tag;
      logic signed [KEY_W-1:0] key;
   } entry_type;

   // one result word waiting in the output register or the skid stage
   typedef struct packed {
      logic      ovf;
      logic      last;
      entry_type ent;
   } slot_type;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_LOAD,
      ST_SCAN,
      ST_STORE,
      ST_EMIT
   } state_type;

endpackage

/* hdl/descending_exchange_sorter_unit.sv */
// ----------------------------------------------------------------------------
// descending_exchange_sorter_unit
// Collects key/tag pairs, exchange-sorts them by descending key in one RAM,
// then streams them out.
// ----------------------------------------------------------------------------
// Input words arrive on req_*: tdata = {entry_tag, sort_key}, tlast closes a
// set. Up to MAX_ENTRIES pairs are held; words beyond that are dropped and
// the run is flagged on rsp_tuser. A word with tlast is stored (if there is
// room) and starts the sort; req_tready stays low until the last result word
// has been read out of the RAM.
// The sort runs on a single 1R1W RAM with a registered read port. Pass i
// keeps entry i in a register and streams entries i+1..n-1 past it, one per
// cycle, writing back the displaced entry on a swap; at the end of the pass
// the held entry is written back to slot i.
// Readout feeds an output register plus a skid stage: one word per cycle
// while rsp_tready is high, and a stalled receiver just holds the words
// (rsp_tdata/tlast/tuser stay put). Once all reads are issued a new set may
// load while the last words are still waiting.
// Reset (synchronous) empties the set and the output; the RAM is not
// cleared, only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module descending_exchange_sorter_unit #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [des_pkg::ENTRY_W-1:0] req_tdata,   // [31:0] sort_key, [47:32] entry_tag
   input  logic                        req_tlast,   // set_end
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [des_pkg::ENTRY_W-1:0] rsp_tdata,   // [31:0] out_key, [47:32] out_tag
   output logic                        rsp_tlast,   // out_last
   output logic                        rsp_tuser    // [0] overflowed
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   // sort store
   des_pkg::entry_type mem [MAX_ENTRIES];
   des_pkg::entry_type rdata_ff;

   des_pkg::state_type state_ff, state_in;

   logic [CW-1:0] fill_ff;
   logic          ovf_ff;
   logic          run_ovf_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] i_ff;
   logic [CW-1:0] j_ff;
   logic [CW-1:0] k_ff;

   des_pkg::entry_type cur_ff;

   logic          rd_vld_ff;
   logic          rd_load_ff;
   logic          rd_emit_ff;
   logic          rd_last_ff;
   logic [AW-1:0] rd_addr_ff;

   des_pkg::slot_type out_ff, skid_ff, rd_slot;
   logic              out_vld_ff, out_vld_in;
   logic              skid_vld_ff, skid_vld_in;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   des_pkg::entry_type mem_wdata;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr;

   logic          req_fire;
   logic          pop;
   logic          has_room;
   logic [CW-1:0] n_in;
   logic          swap;
   logic [1:0]    pending;
   logic          emit_issue;
   logic          out_take_skid;
   logic          out_take_rd;
   logic          skid_take_rd;

   assign req_tready = (state_ff == des_pkg::ST_COLLECT);
   assign req_fire   = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign has_room   = (fill_ff < CW'(MAX_ENTRIES));
   assign n_in       = fill_ff + CW'(has_room);
   assign swap       = ($signed(cur_ff.key) < $signed(rdata_ff.key));

   // words in flight toward the output: register, skid, pending read
   assign pending    = {1'b0, out_vld_ff} + {1'b0, skid_vld_ff} + {1'b0, rd_emit_ff};
   assign emit_issue = (state_ff == des_pkg::ST_EMIT) &&
                       ((pending < 2'd2) || ((pending == 2'd2) && pop));

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         des_pkg::ST_COLLECT: begin
            if (req_fire && req_tlast) begin
               if (n_in >= CW'(2))
                  state_in = des_pkg::ST_LOAD;
               else if (n_in == CW'(1))
                  state_in = des_pkg::ST_EMIT;
            end
         end
         des_pkg::ST_LOAD:  state_in = des_pkg::ST_SCAN;
         des_pkg::ST_SCAN: begin
            if (j_ff >= n_ff)
               state_in = des_pkg::ST_STORE;
         end
         des_pkg::ST_STORE: begin
            if ((i_ff + CW'(2)) < n_ff)
               state_in = des_pkg::ST_LOAD;
            else
               state_in = des_pkg::ST_EMIT;
         end
         des_pkg::ST_EMIT: begin
            if (emit_issue && (k_ff == n_ff - CW'(1)))
               state_in = des_pkg::ST_COLLECT;
         end
         default: state_in = des_pkg::ST_COLLECT;
      endcase
   end

   // ---------------- RAM port control ----------------
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = i_ff[AW-1:0];
      mem_wdata = cur_ff;
      mem_re    = 1'b0;
      mem_raddr = i_ff[AW-1:0];
      case (state_ff)
         des_pkg::ST_COLLECT: begin
            mem_we    = req_fire && has_room;
            mem_waddr = fill_ff[AW-1:0];
            mem_wdata = des_pkg::entry_type'(req_tdata);
         end
         des_pkg::ST_LOAD: begin
            mem_re = 1'b1;
         end
         des_pkg::ST_SCAN: begin
            mem_re    = (j_ff < n_ff);
            mem_raddr = j_ff[AW-1:0];
            // displaced holder goes back where the larger key came from
            mem_we    = rd_vld_ff && !rd_load_ff && swap;
            mem_waddr = rd_addr_ff;
         end
         des_pkg::ST_STORE: begin
            mem_we = 1'b1;
         end
         des_pkg::ST_EMIT: begin
            mem_re    = emit_issue;
            mem_raddr = k_ff[AW-1:0];
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_waddr] <= mem_wdata;
      if (mem_re)
         rdata_ff <= mem[mem_raddr];
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= des_pkg::ST_COLLECT;
         fill_ff     <= '0;
         ovf_ff      <= 1'b0;
         rd_vld_ff   <= 1'b0;
         rd_emit_ff  <= 1'b0;
         rd_load_ff  <= 1'b0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_vld_ff   <= mem_re;
         rd_emit_ff  <= mem_re && (state_ff == des_pkg::ST_EMIT);
         rd_load_ff  <= (state_ff == des_pkg::ST_LOAD);
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
         if (req_fire) begin
            if (req_tlast) begin
               fill_ff <= '0;
               ovf_ff  <= 1'b0;
            end else begin
               fill_ff <= n_in;
               ovf_ff  <= ovf_ff | !has_room;
            end
         end
      end
   end

   // ---------------- sort / readout datapath ----------------
   always_ff @(posedge clock) begin
      rd_addr_ff <= mem_raddr;
      rd_last_ff <= (k_ff == n_ff - CW'(1));
      case (state_ff)
         des_pkg::ST_COLLECT: begin
            if (req_fire && req_tlast) begin
               n_ff       <= n_in;
               run_ovf_ff <= ovf_ff | !has_room;
               i_ff       <= '0;
               k_ff       <= '0;
            end
         end
         des_pkg::ST_LOAD: begin
            j_ff <= i_ff + CW'(1);
         end
         des_pkg::ST_SCAN: begin
            if (rd_vld_ff && (rd_load_ff || swap))
               cur_ff <= rdata_ff;
            if (j_ff < n_ff)
               j_ff <= j_ff + CW'(1);
         end
         des_pkg::ST_STORE: begin
            i_ff <= i_ff + CW'(1);
         end
         des_pkg::ST_EMIT: begin
            if (emit_issue)
               k_ff <= k_ff + CW'(1);
         end
         default: begin
            i_ff <= i_ff;
         end
      endcase
   end

   // ---------------- output register + skid ----------------
   assign rd_slot       = '{ovf: run_ovf_ff, last: rd_last_ff, ent: rdata_ff};
   assign out_take_skid = skid_vld_ff && (!out_vld_ff || pop);
   assign out_take_rd   = !skid_vld_ff && rd_emit_ff && (!out_vld_ff || pop);
   assign skid_take_rd  = rd_emit_ff && !out_take_rd;
   assign out_vld_in    = out_take_skid || out_take_rd || (out_vld_ff && !pop);
   assign skid_vld_in   = skid_take_rd || (skid_vld_ff && !out_take_skid);

   always_ff @(posedge clock) begin
      if (out_take_skid)
         out_ff <= skid_ff;
      else if (out_take_rd)
         out_ff <= rd_slot;
      if (skid_take_rd)
         skid_ff <= rd_slot;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff.ent;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tuser  = out_ff.ovf;

endmodule

/* hdl/des_checker.sv */
// ----------------------------------------------------------------------------
// des_checker
// Port-level checks for the descending exchange sorter, bound to the top.
// ----------------------------------------------------------------------------
module des_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        req_tlast,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [des_pkg::ENTRY_W-1:0] rsp_tdata,
   input logic                        rsp_tlast,
   input logic                        rsp_tuser
);

   // a stalled result word keeps its valid
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // a stalled result word keeps its payload
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast)
                                    && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // closing a set stops intake while the sort runs
   a_set_end_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input taken right after set end");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind descending_exchange_sorter_unit des_checker u_des_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
